// File: rtl/rational_arithmetic_unit_core_defines.svh
// assertion macros for the rational arithmetic unit
// included by the modules that carry concurrent checks
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rau check failed");

// next-cycle implication, disabled during reset
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rau check failed");

`endif

// File: rtl/rau_pkg.sv
// shared constants, codes and controller/datapath command types
// no dependencies
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int NUM_OUT_BITS      = 33;
    localparam int DEN_OUT_BITS      = 31;

    // operation codes
    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    // product select codes for the shared multiplier
    localparam logic [1:0] MSEL_P0 = 2'd0;
    localparam logic [1:0] MSEL_P1 = 2'd1;
    localparam logic [1:0] MSEL_P2 = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       comb;
        logic       gcd_step;
        logic       div_init_num;
        logic       div_init_den;
        logic       div_step;
        logic       finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic gcd_done;
    } t_status;

endpackage

// File: rtl/rau_datapath.sv
// datapath: operand capture, shared multiplier, sign-magnitude combine,
// binary gcd, restoring divider and output registers; uses rau_pkg
module rau_datapath #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  rau_pkg::t_cmd                         i_cmd,
    output rau_pkg::t_status                      o_status,
    input  logic [1:0]                            i_kind,
    input  logic signed [OPERAND_WIDTH-1:0]       i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]       i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]       i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]       i_b_den,
    output logic signed [rau_pkg::NUM_OUT_BITS-1:0] o_res_num,
    output logic [rau_pkg::DEN_OUT_BITS-1:0]      o_res_den
);
    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;
    localparam int KW = $clog2(MW + 1);
    localparam int NB = rau_pkg::NUM_OUT_BITS;
    localparam int DB = rau_pkg::DEN_OUT_BITS;
    localparam int XW = (MW + 1 > NB) ? MW + 1 : NB;
    localparam int DXW = (MW > DB) ? MW : DB;

    // operand registers, sign and magnitude
    rau_pkg::t_kind r_kind;
    logic [W-1:0]   r_an, r_ad, r_bn, r_bd;
    logic           r_an_s, r_ad_s, r_bn_s, r_bd_s;
    // products
    logic [MW-1:0]  r_p0, r_p1, r_p2;
    logic           r_p0_s, r_p1_s, r_p2_s;
    // raw result
    logic [MW-1:0]  r_num, r_den;
    logic           r_num_s, r_den_s;
    // gcd state
    logic [MW-1:0]  r_ga, r_gb, r_g;
    logic [KW-1:0]  r_k;
    // divider state
    logic [MW-1:0]  r_dvd, r_rem, r_qnum;
    logic [MW:0]    trial;

    function automatic logic [W:0] sm_of(input logic [W-1:0] v, input logic fix);
        logic [W-1:0] m;
        logic         s;
        s = v[W-1];
        m = s ? (~v + W'(1)) : v;
        if (fix && (v == '0)) begin
            m = W'(1);
        end
        return {s && !(fix && (v == '0)), m};
    endfunction

    // operand capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= rau_pkg::t_kind'(i_kind);
            {r_an_s, r_an} <= sm_of(i_a_num, 1'b0);
            {r_ad_s, r_ad} <= sm_of(i_a_den, 1'b1);
            {r_bn_s, r_bn} <= sm_of(i_b_num, 1'b0);
            {r_bd_s, r_bd} <= sm_of(i_b_den, 1'b1);
        end
    end

    // shared multiplier operand select
    logic [W-1:0]  mx, my;
    logic          mxs, mys;
    logic [MW-1:0] prod;
    logic          prod_s;

    always_comb begin
        unique case (i_cmd.mul_sel)
            rau_pkg::MSEL_P0: begin
                mx = r_an; mxs = r_an_s;
                my = (r_kind == rau_pkg::KIND_MUL) ? r_bn : r_bd;
                mys = (r_kind == rau_pkg::KIND_MUL) ? r_bn_s : r_bd_s;
            end
            rau_pkg::MSEL_P1: begin
                mx = r_ad; mxs = r_ad_s; my = r_bn; mys = r_bn_s;
            end
            default: begin
                mx = r_ad; mxs = r_ad_s;
                my = (r_kind == rau_pkg::KIND_DIV) ? r_bn : r_bd;
                mys = (r_kind == rau_pkg::KIND_DIV) ? r_bn_s : r_bd_s;
            end
        endcase
        prod   = MW'(mx) * MW'(my);
        prod_s = (prod != '0) && (mxs ^ mys);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_sel)
                rau_pkg::MSEL_P0: begin r_p0 <= prod; r_p0_s <= prod_s; end
                rau_pkg::MSEL_P1: begin r_p1 <= prod; r_p1_s <= prod_s; end
                default:          begin r_p2 <= prod; r_p2_s <= prod_s; end
            endcase
        end
    end

    // sign-magnitude combine of the cross products
    logic [MW-1:0] c_num, c_den;
    logic          c_num_s, c_den_s, y_s;
    logic [MW-1:0] y_m;

    always_comb begin
        y_m = r_p1;
        y_s = (r_kind == rau_pkg::KIND_SUB) ? (r_p1_s ^ (r_p1 != '0)) : r_p1_s;
        if ((r_kind == rau_pkg::KIND_MUL) || (r_kind == rau_pkg::KIND_DIV)) begin
            c_num = r_p0; c_num_s = r_p0_s;
        end else if (r_p0_s == y_s) begin
            c_num = r_p0 + y_m; c_num_s = r_p0_s;
        end else if (r_p0 >= y_m) begin
            c_num = r_p0 - y_m; c_num_s = r_p0_s;
        end else begin
            c_num = y_m - r_p0; c_num_s = y_s;
        end
        if (c_num == '0) begin
            c_num_s = 1'b0;
        end
        c_den   = (r_p2 == '0) ? MW'(1) : r_p2;
        c_den_s = (r_p2 == '0) ? 1'b0 : r_p2_s;
    end

    // binary gcd
    assign o_status.gcd_done = (r_ga == '0) || (r_gb == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.comb) begin
            r_num <= c_num; r_num_s <= c_num_s;
            r_den <= c_den; r_den_s <= c_den_s;
            r_ga  <= c_num; r_gb <= c_den; r_k <= '0;
        end else if (i_cmd.gcd_step && !o_status.gcd_done) begin
            priority if (!r_ga[0] && !r_gb[0]) begin
                r_ga <= r_ga >> 1; r_gb <= r_gb >> 1; r_k <= r_k + KW'(1);
            end else if (!r_ga[0]) begin
                r_ga <= r_ga >> 1;
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga >= r_gb) begin
                r_ga <= r_ga - r_gb;
            end else begin
                r_gb <= r_gb - r_ga;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    assign trial = {r_rem, r_dvd[MW-1]} - {1'b0, r_g};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init_num) begin
            r_g   <= (r_ga | r_gb) << r_k;
            r_dvd <= r_num;
            r_rem <= '0;
        end else if (i_cmd.div_init_den) begin
            r_qnum <= r_dvd;
            r_dvd  <= r_den;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            if (!trial[MW]) begin
                r_rem <= trial[MW-1:0];
                r_dvd <= {r_dvd[MW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[MW-2:0], r_dvd[MW-1]};
                r_dvd <= {r_dvd[MW-2:0], 1'b0};
            end
        end
    end

    // output registers with sign applied
    logic [XW-1:0]  qx;
    logic [DXW-1:0] dx;
    logic           neg;

    always_comb begin
        qx  = {{(XW - MW){1'b0}}, r_qnum};
        dx  = {{(DXW - MW){1'b0}}, r_dvd};
        neg = (r_qnum != '0) && (r_num_s ^ r_den_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_res_num <= neg ? NB'(~qx + XW'(1)) : NB'(qx);
            o_res_den <= dx[DB-1:0];
        end
    end

endmodule

// File: rtl/rau_ctrl.sv
// controller: sequences multiply, combine, gcd and divide steps
// uses rau_pkg and rational_arithmetic_unit_core_defines.svh
`include "rational_arithmetic_unit_core_defines.svh"

module rau_ctrl #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output logic             o_done,
    output rau_pkg::t_cmd    o_cmd,
    input  rau_pkg::t_status i_status
);
    localparam int MW = 2 * OPERAND_WIDTH;
    localparam int CW = $clog2(MW);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_COMB = 8'b0000_0100,
        S_GCD  = 8'b0000_1000,
        S_DIVN = 8'b0001_0000,
        S_SWAP = 8'b0010_0000,
        S_DIVD = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        o_cmd   = '0;
        o_cmd.mul_sel = r_cnt[1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                    n_cnt      = '0;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_cnt        = r_cnt + CW'(1);
                if (r_cnt == CW'(2)) begin
                    n_state = S_COMB;
                end
            end
            S_COMB: begin
                o_cmd.comb = 1'b1;
                n_state    = S_GCD;
            end
            S_GCD: begin
                o_cmd.gcd_step = 1'b1;
                if (i_status.gcd_done) begin
                    o_cmd.div_init_num = 1'b1;
                    n_state = S_DIVN;
                    n_cnt   = '0;
                end
            end
            S_DIVN: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (r_cnt == CW'(MW - 1)) begin
                    n_state = S_SWAP;
                end
            end
            S_SWAP: begin
                o_cmd.div_init_den = 1'b1;
                n_state = S_DIVD;
                n_cnt   = '0;
            end
            S_DIVD: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (r_cnt == CW'(MW - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    // a transfer in always starts a run
    `RAU_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, r_state == S_MUL)
    // result strobe only follows the finish step
    `RAU_ASSERT_IMP(a_done_src, i_clk, i_rst_n, r_done, $past(r_state == S_FIN))
    // strobe comes with the block free again
    `RAU_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !o_busy)

endmodule

// File: rtl/rational_arithmetic_unit_core.sv
// rational arithmetic unit: fraction add/sub/mul/div reduced by gcd
// sequence: load, 3 multiply, combine, gcd steps until one value is zero, numerator divider pass,
//   swap, denominator divider pass, finish
// one item at a time; busy drops with o_done, the next transfer can be taken then
// result shows on o_done for one cycle; the receiver cannot stall
// synchronous active-low reset returns the controller to idle
module rational_arithmetic_unit_core #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    output logic                                    o_busy,
    input  logic [1:0]                              i_kind,
    input  logic signed [OPERAND_WIDTH-1:0]         i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]         i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]         i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]         i_b_den,
    output logic                                    o_done,
    output logic signed [rau_pkg::NUM_OUT_BITS-1:0] o_res_num,
    output logic [rau_pkg::DEN_OUT_BITS-1:0]        o_res_den
);
    rau_pkg::t_cmd    cmd;
    rau_pkg::t_status status;

    rau_ctrl #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_cmd    (cmd),
        .i_status (status)
    );

    rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_kind    (i_kind),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den)
    );

endmodule
